### rtl/mmp_pkg.sv
// mikey message parser package: trailing field code, status and outcome constants
// no dependencies
`timescale 1ns / 1ps
package mmp_pkg;
   localparam logic [5:0] FC_TRAILING = 6'd40;
   localparam logic [1:0] ST_INSIDE   = 2'd0;
   localparam logic [1:0] ST_DONE     = 2'd1;
   localparam logic [1:0] ST_ERROR    = 2'd2;
   localparam logic [1:0] ST_TRAIL    = 2'd3;
   localparam logic [1:0] OUT_PARSING = 2'd0;
   localparam logic [1:0] OUT_DONE    = 2'd1;
   localparam logic [1:0] OUT_TRAIL   = 2'd2;
   localparam logic [1:0] OUT_ERROR   = 2'd3;
   localparam logic [15:0] CS_ENTRY_LEN = 16'd4;
   localparam logic [15:0] MAC_LEN      = 16'd20;
   localparam logic [15:0] TS_LONG_LEN  = 16'd8;
   localparam logic [15:0] TS_SHORT_LEN = 16'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [5:0]  field_code;
      logic [15:0] field_offset;
      logic [7:0]  byte_value;
      logic [1:0]  byte_status;
      logic [1:0]  message_result;
   } rsp_type;
endpackage

### rtl/mmp_stream_if.sv
// valid/ready channel carrying one parser item
// depends on nothing; payload type is a parameter
`timescale 1ns / 1ps
interface mmp_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/mikey_message_parser.sv
// mikey message parser top level: byte-at-a-time field tagger
// depends on mmp_pkg and mmp_stream_if
`timescale 1ns / 1ps
// Takes one message byte per cycle while the output is not stalled and returns
// one registered tagged item per byte in the cycle after the byte is taken. An
// item is accepted on every cycle the output register is empty or being emptied,
// so the rate is one byte per clock; only the result register is a pipeline stage.
module mikey_message_parser (
   input logic clock,
   input logic reset,
   mmp_stream_if.sink   req,
   mmp_stream_if.source rsp
);
   import mmp_pkg::*;

   logic [5:0]  state_ff, state_in;
   logic [15:0] pos_ff, pos_in, len_ff, len_in, enc_ff, enc_in, pol_ff, pol_in;
   logic [7:0]  sess_ff, sess_in, next_ff, next_in;
   logic [3:0]  kf_ff, kf_in;
   logic [1:0]  outc_ff, outc_in;
   logic        vld_ff;
   rsp_type     out_ff, out_in;
   logic        take;
   logic [7:0]  b;
   logic [1:0]  st;
   logic [15:0] len2, posp1;
   logic        data_end;

   assign req.ready = !vld_ff || rsp.ready;
   assign take = req.valid && req.ready;
   assign rsp.valid = vld_ff;
   assign rsp.payload = out_ff;
   assign b = req.payload.in_byte;
   assign len2 = (pos_ff == 16'd0) ? {8'd0, b} : {len_ff[7:0], b};
   assign posp1 = pos_ff + 16'd1;
   assign data_end = ({1'b0, pos_ff} + 17'd1) >= {1'b0, len_ff};

   always_comb begin
      logic [1:0] res;
      logic [3:0] ktype;
      state_in = state_ff; pos_in = pos_ff; len_in = len_ff; enc_in = enc_ff;
      pol_in = pol_ff; sess_in = sess_ff; next_in = next_ff; kf_in = kf_ff;
      outc_in = outc_ff; st = ST_INSIDE; res = OUT_PARSING;
      ktype = b[7:4];
      out_in.field_code = state_ff;
      out_in.field_offset = pos_ff;
      out_in.byte_value = b;
      if (outc_ff != OUT_PARSING) begin
         out_in.field_code = FC_TRAILING;
         if (pos_ff != 16'hFFFF) pos_in = posp1;
         if (outc_ff == OUT_DONE) outc_in = OUT_TRAIL;
         st = ST_TRAIL;
      end else begin
         if (state_ff >= 6'd13 && state_ff <= 6'd24 && enc_ff != 16'd0)
            enc_in = enc_ff - 16'd1;
         if (state_ff >= 6'd34 && state_ff <= 6'd36 && pol_ff != 16'd0)
            pol_in = pol_ff - 16'd1;
         // next-state targets expressed as small codes; finish resolved below
         begin : body
            logic fin, err, after_key, after_salt, endsub, endpar;
            fin = 1'b0; err = 1'b0; after_key = 1'b0; after_salt = 1'b0;
            endsub = 1'b0; endpar = 1'b0;
            case (state_ff)
               6'd0, 6'd1, 6'd3, 6'd7, 6'd11, 6'd13, 6'd31, 6'd34: begin
                  state_in = state_ff + 6'd1; pos_in = '0;
               end
               6'd2, 6'd10, 6'd27, 6'd30, 6'd37: begin
                  next_in = b; state_in = state_ff + 6'd1; pos_in = '0;
               end
               6'd4, 6'd8: begin
                  if (posp1 >= CS_ENTRY_LEN) begin
                     state_in = state_ff + 6'd1; pos_in = '0;
                  end else pos_in = posp1;
               end
               6'd5: begin sess_in = b; state_in = 6'd6; pos_in = '0; end
               6'd6: begin
                  if (b != 8'd0) err = 1'b1;
                  else if (sess_ff == 8'd0) fin = 1'b1;
                  else begin state_in = 6'd7; pos_in = '0; end
               end
               6'd9: begin
                  if (posp1 >= CS_ENTRY_LEN) begin
                     sess_in = sess_ff - 8'd1;
                     if (sess_ff == 8'd1) fin = 1'b1;
                     else begin state_in = 6'd7; pos_in = '0; end
                  end else pos_in = posp1;
               end
               6'd12: begin
                  len_in = len2;
                  if (pos_ff == 16'd0) pos_in = 16'd1;
                  else begin
                     enc_in = len2; pos_in = '0;
                     state_in = (len2 == 16'd0) ? 6'd25 : 6'd13;
                  end
               end
               6'd14: begin
                  if (ktype > 4'd3) err = 1'b1;
                  else begin
                     kf_in = {kf_ff[3], b[3:0] == 4'd2, b[3:0] == 4'd1, ktype[0]};
                     state_in = 6'd15; pos_in = '0;
                  end
               end
               6'd15, 6'd17: begin
                  len_in = len2;
                  if (pos_ff == 16'd0) pos_in = 16'd1;
                  else if (len2 == 16'd0) begin
                     if (state_ff == 6'd15) after_key = 1'b1; else after_salt = 1'b1;
                  end else begin state_in = state_ff + 6'd1; pos_in = '0; end
               end
               6'd16: if (data_end) after_key = 1'b1; else pos_in = posp1;
               6'd18: if (data_end) after_salt = 1'b1; else pos_in = posp1;
               6'd19, 6'd23: begin
                  len_in = {8'd0, b};
                  if (b == 8'd0) endsub = 1'b1;
                  else begin state_in = state_ff + 6'd1; pos_in = '0; end
               end
               6'd20, 6'd24: if (data_end) endsub = 1'b1; else pos_in = posp1;
               6'd21: begin
                  len_in = {8'd0, b}; pos_in = '0;
                  state_in = (b == 8'd0) ? 6'd23 : 6'd22;
               end
               6'd22: if (data_end) begin state_in = 6'd23; pos_in = '0; end
                      else pos_in = posp1;
               6'd25: begin
                  if (b > 8'd1) err = 1'b1;
                  else if (b == 8'd1) begin state_in = 6'd26; pos_in = '0; end
                  else fin = 1'b1;
               end
               6'd26: if (posp1 >= MAC_LEN) fin = 1'b1; else pos_in = posp1;
               6'd28: begin
                  if (b > 8'd2) err = 1'b1;
                  else begin
                     kf_in[3] = (b < 8'd2); state_in = 6'd29; pos_in = '0;
                  end
               end
               6'd29: if (posp1 >= (kf_ff[3] ? TS_LONG_LEN : TS_SHORT_LEN)) fin = 1'b1;
                      else pos_in = posp1;
               6'd32: begin
                  if (b != 8'd0) err = 1'b1;
                  else begin state_in = 6'd33; pos_in = '0; end
               end
               6'd33: begin
                  len_in = len2;
                  if (pos_ff == 16'd0) pos_in = 16'd1;
                  else begin
                     pol_in = len2;
                     if (len2 == 16'd0) fin = 1'b1;
                     else begin state_in = 6'd34; pos_in = '0; end
                  end
               end
               6'd35: begin
                  len_in = {8'd0, b};
                  if (b == 8'd0) endpar = 1'b1;
                  else begin state_in = 6'd36; pos_in = '0; end
               end
               6'd36: if (data_end) endpar = 1'b1; else pos_in = posp1;
               6'd38: begin
                  len_in = {8'd0, b};
                  if (b == 8'd0) fin = 1'b1;
                  else begin state_in = 6'd39; pos_in = '0; end
               end
               6'd39: if (data_end) fin = 1'b1; else pos_in = posp1;
               default: err = 1'b1;
            endcase
            if (after_key) begin
               if (kf_in[0]) begin state_in = 6'd17; pos_in = '0; end
               else after_salt = 1'b1;
            end
            if (after_salt) begin
               pos_in = '0;
               if (kf_in[1]) state_in = 6'd19;
               else if (kf_in[2]) state_in = 6'd21;
               else endsub = 1'b1;
            end
            if (endsub) begin
               pos_in = '0; state_in = (enc_in == 16'd0) ? 6'd25 : 6'd13;
            end
            if (endpar) begin
               if (pol_in == 16'd0) fin = 1'b1;
               else begin state_in = 6'd34; pos_in = '0; end
            end
            if (fin) begin
               pos_in = '0;
               case (next_in)
                  8'd0: begin outc_in = OUT_DONE; st = ST_DONE; end
                  8'd1: state_in = 6'd10;
                  8'd5: state_in = 6'd27;
                  8'd10: state_in = 6'd30;
                  8'd11: state_in = 6'd37;
                  default: err = 1'b1;
               endcase
            end
            if (!err && !fin && outc_in == OUT_PARSING) begin
               if (state_in >= 6'd13 && state_in <= 6'd24 && enc_in == 16'd0) err = 1'b1;
               if (state_in >= 6'd34 && state_in <= 6'd36 && pol_in == 16'd0) err = 1'b1;
            end
            if (err) begin
               outc_in = OUT_ERROR; pos_in = '0; st = ST_ERROR;
            end
         end
      end
      if (req.payload.last_byte) begin
         if (outc_in == OUT_PARSING) begin st = ST_ERROR; res = OUT_ERROR; end
         else res = outc_in;
         state_in = '0; pos_in = '0; len_in = '0; enc_in = '0; pol_in = '0;
         sess_in = '0; next_in = '0; kf_in = '0; outc_in = OUT_PARSING;
      end
      out_in.byte_status = st;
      out_in.message_result = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0; pos_ff <= '0; len_ff <= '0; enc_ff <= '0; pol_ff <= '0;
         sess_ff <= '0; next_ff <= '0; kf_ff <= '0; outc_ff <= OUT_PARSING;
         vld_ff <= 1'b0;
      end else begin
         if (take) begin
            state_ff <= state_in; pos_ff <= pos_in; len_ff <= len_in;
            enc_ff <= enc_in; pol_ff <= pol_in; sess_ff <= sess_in;
            next_ff <= next_in; kf_ff <= kf_in; outc_ff <= outc_in;
         end
         if (req.ready) vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) out_ff <= out_in;
   end
endmodule

### tb/mikey_message_parser_checker.sv
// mikey message parser checker: watches the byte and tag channels, predicts tags
// depends on mmp_pkg
`timescale 1ns / 1ps
module mikey_message_parser_checker
   import mmp_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   req_valid,
   input  logic   req_ready,
   input  req_type req_item,
   input  logic   rsp_valid,
   input  logic   rsp_ready,
   input  rsp_type rsp_item,
   output int     fail_count,
   output int     pending_tags
);
   logic [5:0]  pstate;
   logic [15:0] fpos, flen, enc_left, pol_left;
   logic [7:0]  cs_left, next_pl;
   logic [4:0]  kflags;
   logic [1:0]  outcome;
   rsp_type     tag_queue[$];

   assign pending_tags = tag_queue.size();

   function automatic void clear_state();
      pstate = 0; fpos = 0; flen = 0; enc_left = 0; pol_left = 0;
      cs_left = 0; next_pl = 0; kflags = 0; outcome = OUT_PARSING;
   endfunction

   function automatic void goto_state(logic [5:0] s);
      pstate = s;
      fpos = 0;
   endfunction

   function automatic logic [1:0] flag_error();
      outcome = OUT_ERROR;
      fpos = 0;
      return ST_ERROR;
   endfunction

   function automatic logic [1:0] close_payload();
      case (next_pl)
         8'd0: begin
            outcome = OUT_DONE; fpos = 0; return ST_DONE;
         end
         8'd1: goto_state(10);
         8'd5: goto_state(27);
         8'd10: goto_state(30);
         8'd11: goto_state(37);
         default: return flag_error();
      endcase
      return ST_INSIDE;
   endfunction

   function automatic void close_sub();
      goto_state(enc_left == 0 ? 6'd25 : 6'd13);
   endfunction

   function automatic void past_salt();
      if (kflags[1]) goto_state(19);
      else if (kflags[2]) goto_state(21);
      else close_sub();
   endfunction

   function automatic void past_key();
      if (kflags[0]) goto_state(17);
      else past_salt();
   endfunction

   function automatic logic [1:0] close_param();
      if (pol_left == 0) return close_payload();
      goto_state(34);
      return ST_INSIDE;
   endfunction

   function automatic bit field_ends(logic [15:0] len);
      if ({1'b0, fpos} + 17'd1 >= {1'b0, len}) return 1;
      fpos++;
      return 0;
   endfunction

   function automatic void grab_len(logic [7:0] b);
      if (fpos == 0) flen = {8'd0, b};
      else flen = {flen[7:0], b};
   endfunction

   function automatic logic [1:0] parse_one(logic [7:0] b);
      logic [1:0] st;
      logic [5:0] s;
      logic [3:0] ktype, kv;
      st = ST_INSIDE;
      s = pstate;
      if (s >= 13 && s <= 24 && enc_left > 0) enc_left--;
      if (s >= 34 && s <= 36 && pol_left > 0) pol_left--;
      case (s)
         0: goto_state(1);
         1: goto_state(2);
         2: begin next_pl = b; goto_state(3); end
         3: goto_state(4);
         4: if (field_ends(CS_ENTRY_LEN)) goto_state(5);
         5: begin cs_left = b; goto_state(6); end
         6: begin
            if (b != 0) return flag_error();
            if (cs_left == 0) return close_payload();
            goto_state(7);
         end
         7: goto_state(8);
         8: if (field_ends(CS_ENTRY_LEN)) goto_state(9);
         9: if (field_ends(CS_ENTRY_LEN)) begin
            cs_left--;
            if (cs_left == 0) return close_payload();
            goto_state(7);
         end
         10: begin next_pl = b; goto_state(11); end
         11: goto_state(12);
         12: begin
            grab_len(b);
            if (fpos == 0) fpos = 1;
            else begin
               enc_left = flen;
               goto_state(enc_left == 0 ? 6'd25 : 6'd13);
            end
         end
         13: goto_state(14);
         14: begin
            ktype = b[7:4];
            kv = b[3:0];
            if (ktype > 3) return flag_error();
            kflags = {1'b0, kflags[3], kv == 2, kv == 1, ktype[0]};
            goto_state(15);
         end
         15: begin
            grab_len(b);
            if (fpos == 0) fpos = 1;
            else if (flen == 0) past_key();
            else goto_state(16);
         end
         16: if (field_ends(flen)) past_key();
         17: begin
            grab_len(b);
            if (fpos == 0) fpos = 1;
            else if (flen == 0) past_salt();
            else goto_state(18);
         end
         18: if (field_ends(flen)) past_salt();
         19: begin flen = b; if (b == 0) close_sub(); else goto_state(20); end
         20: if (field_ends(flen)) close_sub();
         21: begin flen = b; goto_state(b == 0 ? 6'd23 : 6'd22); end
         22: if (field_ends(flen)) goto_state(23);
         23: begin flen = b; if (b == 0) close_sub(); else goto_state(24); end
         24: if (field_ends(flen)) close_sub();
         25: begin
            if (b > 1) return flag_error();
            if (b == 1) goto_state(26);
            else return close_payload();
         end
         26: if (field_ends(MAC_LEN)) return close_payload();
         27: begin next_pl = b; goto_state(28); end
         28: begin
            if (b > 2) return flag_error();
            kflags[3] = (b < 2);
            goto_state(29);
         end
         29: if (field_ends(kflags[3] ? TS_LONG_LEN : TS_SHORT_LEN)) return close_payload();
         30: begin next_pl = b; goto_state(31); end
         31: goto_state(32);
         32: begin
            if (b != 0) return flag_error();
            goto_state(33);
         end
         33: begin
            grab_len(b);
            if (fpos == 0) fpos = 1;
            else begin
               pol_left = flen;
               if (pol_left == 0) return close_payload();
               goto_state(34);
            end
         end
         34: goto_state(35);
         35: begin
            flen = b;
            if (b == 0) st = close_param(); else goto_state(36);
         end
         36: if (field_ends(flen)) st = close_param();
         37: begin next_pl = b; goto_state(38); end
         38: begin
            flen = b;
            if (b == 0) return close_payload();
            goto_state(39);
         end
         39: if (field_ends(flen)) return close_payload();
         default: return flag_error();
      endcase
      if (outcome == OUT_PARSING) begin
         if (pstate >= 13 && pstate <= 24 && enc_left == 0) return flag_error();
         if (pstate >= 34 && pstate <= 36 && pol_left == 0) return flag_error();
      end
      return st;
   endfunction

   function automatic rsp_type tag_byte(req_type r);
      rsp_type t;
      t.byte_value = r.in_byte;
      t.message_result = OUT_PARSING;
      if (outcome != OUT_PARSING) begin
         t.field_code = FC_TRAILING;
         t.field_offset = fpos;
         if (fpos != 16'hFFFF) fpos++;
         if (outcome == OUT_DONE) outcome = OUT_TRAIL;
         t.byte_status = ST_TRAIL;
      end else begin
         t.field_code = pstate;
         t.field_offset = fpos;
         t.byte_status = parse_one(r.in_byte);
      end
      if (r.last_byte) begin
         if (outcome == OUT_PARSING) begin
            t.byte_status = ST_ERROR;
            t.message_result = OUT_ERROR;
         end else t.message_result = outcome;
         clear_state();
      end
      return t;
   endfunction

   always_ff @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_state();
         tag_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) tag_queue.push_back(tag_byte(req_item));
         if (rsp_valid && rsp_ready) begin
            if (tag_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected item %p", rsp_item);
               fail_count <= fail_count + 1;
            end else begin
               want = tag_queue.pop_front();
               if (want !== rsp_item) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p actual %p", want, rsp_item);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### tb/mikey_message_parser_tb.sv
// mikey message parser testbench top: clock, reset, message stimulus, verdict
// depends on mmp_pkg, mmp_stream_if, mikey_message_parser and its checker
`timescale 1ns / 1ps
module mikey_message_parser_tb;
   import mmp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic clock, reset;
   int   fail_count, pending_tags, stall_cycles, sent;
   bit   quiet, drained;
   byte unsigned msg[$];

   mmp_stream_if #(.payload_type(req_type)) req_ch ();
   mmp_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   mikey_message_parser u_top (.clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch));

   mikey_message_parser_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_item(req_ch.payload),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_item(rsp_ch.payload),
      .fail_count(fail_count), .pending_tags(pending_tags)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("mikey_message_parser_tb: errors");
         $finish;
      end
   end

   // result side backpressure
   initial begin
      rsp_ch.ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
      end
   end

   task automatic send_byte(byte unsigned b, bit last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.payload <= '{in_byte: b, last_byte: last};
      @(posedge clock iff req_ch.ready);
      sent++;
   endtask

   task automatic send_msg();
      for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
      msg.delete();
   endtask

   function automatic byte unsigned rb();
      return byte'($urandom_range(0, 255));
   endfunction

   // builds a mostly valid message with random content
   task automatic build_msg(bit mangle);
      int ncs, nxt, plist[$], klen, slen, n, pick, enc_start;
      ncs = $urandom_range(0, 2);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 3);
         plist.push_back(pick == 0 ? 1 : pick == 1 ? 5 : pick == 2 ? 10 : 11);
      end
      plist.push_back(0);
      msg.push_back(rb()); msg.push_back(rb()); msg.push_back(8'(plist[0]));
      msg.push_back(rb());
      repeat (4) msg.push_back(rb());
      msg.push_back(8'(ncs)); msg.push_back(8'd0);
      repeat (ncs * 9) msg.push_back(rb());
      for (int p = 0; p + 1 < plist.size(); p++) begin
         nxt = plist[p + 1];
         case (plist[p])
            1: begin
               byte unsigned body[$];
               int kv, kt;
               repeat ($urandom_range(0, 2)) begin
                  kt = $urandom_range(0, 3);
                  kv = $urandom_range(0, 3);
                  klen = $urandom_range(0, 6);
                  body.push_back(rb()); body.push_back({kt[3:0], kv[3:0]});
                  body.push_back(8'd0); body.push_back(8'(klen));
                  repeat (klen) body.push_back(rb());
                  if (kt[0]) begin
                     slen = $urandom_range(0, 3);
                     body.push_back(8'd0); body.push_back(8'(slen));
                     repeat (slen) body.push_back(rb());
                  end
                  if (kv == 1) begin
                     slen = $urandom_range(0, 3); body.push_back(8'(slen));
                     repeat (slen) body.push_back(rb());
                  end else if (kv == 2) repeat (2) begin
                     slen = $urandom_range(0, 3); body.push_back(8'(slen));
                     repeat (slen) body.push_back(rb());
                  end
               end
               msg.push_back(8'(nxt)); msg.push_back(rb());
               msg.push_back(8'(body.size() >> 8)); msg.push_back(8'(body.size()));
               foreach (body[i]) msg.push_back(body[i]);
               pick = $urandom_range(0, 1);
               msg.push_back(8'(pick));
               if (pick) repeat (20) msg.push_back(rb());
            end
            5: begin
               pick = $urandom_range(0, 2);
               msg.push_back(8'(nxt)); msg.push_back(8'(pick));
               repeat (pick < 2 ? 8 : 4) msg.push_back(rb());
            end
            10: begin
               byte unsigned body[$];
               repeat ($urandom_range(0, 2)) begin
                  slen = $urandom_range(0, 4);
                  body.push_back(rb()); body.push_back(8'(slen));
                  repeat (slen) body.push_back(rb());
               end
               msg.push_back(8'(nxt)); msg.push_back(rb()); msg.push_back(8'd0);
               msg.push_back(8'd0); msg.push_back(8'(body.size()));
               foreach (body[i]) msg.push_back(body[i]);
            end
            default: begin
               slen = $urandom_range(0, 6);
               msg.push_back(8'(nxt)); msg.push_back(8'(slen));
               repeat (slen) msg.push_back(rb());
            end
         endcase
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) msg.push_back(rb());
      if (mangle && msg.size() > 1) begin
         pick = $urandom_range(0, 2);
         if (pick == 0) msg[$urandom_range(0, msg.size() - 1)] = rb();
         else if (pick == 1) repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
         else msg[2] = byte'($urandom_range(2, 255));
      end
   endtask

   initial begin
      reset = 1;
      quiet = 0;
      drained = 0;
      sent = 0;
      req_ch.valid = 0;
      req_ch.payload = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      // directed: header with bad map type, then kemac with key and salt that overruns its encrypted length
      msg = '{8'h01, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h07};
      send_msg();
      msg = '{8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h11, 8'h00, 8'h01, 8'hAA,
              8'h00, 8'h01, 8'h55, 8'h00, 8'h01, 8'h80};
      send_msg();
      // unknown payload type, then lone byte, then trailing junk after done
      msg = '{8'h01, 8'h00, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_msg();
      send_byte(8'hFF, 1);
      msg = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
              8'hFF, 8'h00};
      send_msg();
      while (sent < 800) begin
         build_msg($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 5)) msg.push_back(rb());
         send_msg();
         if (!drained && sent > 400) begin
            req_ch.valid <= 0;
            @(posedge clock iff pending_tags == 0);
            drained = 1;
         end
         if (sent > 650) quiet = 1;
      end
      req_ch.valid <= 0;
      @(posedge clock iff pending_tags == 0);
      repeat (5) @(posedge clock);
      if (fail_count == 0) $display("mikey_message_parser_tb: clean");
      else $display("mikey_message_parser_tb: errors");
      $finish;
   end
endmodule

### mikey_message_parser.f
rtl/mmp_pkg.sv
rtl/mmp_stream_if.sv
rtl/mikey_message_parser.sv
tb/mikey_message_parser_checker.sv
tb/mikey_message_parser_tb.sv
